// ===== design/sbusfd_pkg.sv =====
package sbusfd_pkg;

    // frame layout
    localparam int unsigned FRAME_LEN    = 25;
    localparam int unsigned STORE_LEN    = FRAME_LEN - 1;
    localparam int unsigned COUNT_W      = 5;
    localparam int unsigned CHAN_W       = 11;
    localparam int unsigned NUM_CHANNELS = 10;
    localparam int unsigned FAILSAFE_IDX = 23;
    localparam int unsigned FAILSAFE_BIT = 3;
    // channel bit string starts at frame byte 1
    localparam int unsigned CHAN_BASE    = 8;

    localparam logic [7:0] HDR_BYTE = 8'h0F;
    localparam logic [7:0] FTR_BYTE = 8'h00;

    localparam logic [COUNT_W-1:0] FOOTER_POS = COUNT_W'(STORE_LEN);

    // byte k of the frame sits at bits 8k+7..8k
    typedef logic [STORE_LEN-1:0][7:0] frame_bytes_t;
    typedef logic [NUM_CHANNELS-1:0][CHAN_W-1:0] chan_array_t;

    typedef struct packed {
        chan_array_t chans;
        logic        failsafe;
    } frame_fields_t;

endpackage

// ===== design/sbusfd_unpack.sv =====
module sbusfd_unpack (
    input  sbusfd_pkg::frame_bytes_t  frame,
    output sbusfd_pkg::frame_fields_t fields
);
    import sbusfd_pkg::*;

    // frame bytes as one bit string, byte k at bits 8k+7..8k
    logic [STORE_LEN*8-1:0] frame_flat;

    assign frame_flat = frame;

    // little-endian 11-bit slices of the bit string from byte 1
    always_comb
    begin
        for (int unsigned i = 0; i < NUM_CHANNELS; i++)
        begin
            fields.chans[i] = frame_flat[CHAN_BASE + CHAN_W * i +: CHAN_W];
        end
        fields.failsafe = frame[FAILSAFE_IDX][FAILSAFE_BIT];
    end

endmodule

// ===== design/sbus_frame_decoder_core.sv =====
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+-----------------------------------
// input    | in        | in_valid / in_stall  | rx_byte
// output   | out       | out_valid / out_stall| chan_0..chan_9, failsafe_on,
//          |           |                      | frame_good
//
// one byte is taken per cycle while in_stall is low; a frame result appears in the cycle after its
// footer beat and sits in the output register until taken.
// in_stall rises only when a footer beat would land on a result still held
// by out_stall; all other bytes flow on regardless of the output side.
// rst_n clears the byte count, the latched channels and failsafe and the
// output valid; the frame byte shift line is not reset.
module sbus_frame_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [10:0] chan_0,
    output logic [10:0] chan_1,
    output logic [10:0] chan_2,
    output logic [10:0] chan_3,
    output logic [10:0] chan_4,
    output logic [10:0] chan_5,
    output logic [10:0] chan_6,
    output logic [10:0] chan_7,
    output logic [10:0] chan_8,
    output logic [10:0] chan_9,
    output logic        failsafe_on,
    output logic        frame_good
);
    import sbusfd_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    frame_bytes_t       frame_reg;
    chan_array_t        chans_reg;
    logic               failsafe_reg;
    logic               good_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    frame_fields_t      fields;
    logic               accept;
    logic               at_footer;
    logic               take_byte;
    logic               finish;
    logic               good;

    // beat handshake
    assign at_footer = (count_reg >= FOOTER_POS);
    assign in_stall  = at_footer && out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign take_byte = accept && !at_footer && ((count_reg != '0) || (rx_byte == HDR_BYTE));
    assign finish    = accept && at_footer;
    assign good      = (rx_byte == FTR_BYTE);

    // byte counter
    always_comb
    begin
        count_next = count_reg;
        if (finish)
        begin
            count_next = '0;
        end
        else if (take_byte)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    // output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // frame bytes shift in from the top, byte 0 ends at index 0
    always_ff @(posedge clk)
    begin
        if (take_byte)
        begin
            frame_reg <= {rx_byte, frame_reg[STORE_LEN-1:1]};
        end
    end

    sbusfd_unpack u_unpack (
        .frame  (frame_reg),
        .fields (fields)
    );

    // result register doubles as the latched channels and failsafe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chans_reg    <= '0;
            failsafe_reg <= 1'b0;
            good_reg     <= 1'b0;
        end
        else if (finish)
        begin
            good_reg <= good;
            if (good)
            begin
                chans_reg    <= fields.chans;
                failsafe_reg <= fields.failsafe;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign chan_0      = chans_reg[0];
    assign chan_1      = chans_reg[1];
    assign chan_2      = chans_reg[2];
    assign chan_3      = chans_reg[3];
    assign chan_4      = chans_reg[4];
    assign chan_5      = chans_reg[5];
    assign chan_6      = chans_reg[6];
    assign chan_7      = chans_reg[7];
    assign chan_8      = chans_reg[8];
    assign chan_9      = chans_reg[9];
    assign failsafe_on = failsafe_reg;
    assign frame_good  = good_reg;

endmodule

// ===== design/sbusfd_checker.sv =====
module sbusfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [10:0] chan_0,
    input logic [10:0] chan_9,
    input logic        failsafe_on,
    input logic        frame_good
);

    // a held result keeps its beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(chan_0) && $stable(chan_9)
            && $stable(failsafe_on) && $stable(frame_good))
        else $error("output beat changed while stalled");

    // input only backs up behind a stalled result
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

    // a new result only follows an accepted input beat
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall))
        else $error("result appeared without an input beat");

    // a stale frame never changes the latched chan_0
    a_stale_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_good |-> chan_0 == $past(chan_0) || $rose(out_valid)
            || !$past(rst_n))
        else $error("channels changed on a result while held");

endmodule

bind sbus_frame_decoder_core sbusfd_checker u_sbusfd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .chan_0      (chan_0),
    .chan_9      (chan_9),
    .failsafe_on (failsafe_on),
    .frame_good  (frame_good)
);

// ===== verif/sbus_frame_checker.sv =====
module sbus_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [10:0] chan_0,
    input  logic [10:0] chan_1,
    input  logic [10:0] chan_2,
    input  logic [10:0] chan_3,
    input  logic [10:0] chan_4,
    input  logic [10:0] chan_5,
    input  logic [10:0] chan_6,
    input  logic [10:0] chan_7,
    input  logic [10:0] chan_8,
    input  logic [10:0] chan_9,
    input  logic        failsafe_on,
    input  logic        frame_good,
    output int          mismatch_count,
    output int          frames_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import sbusfd_pkg::*;

    typedef struct packed {
        chan_array_t chans;
        logic        failsafe;
        logic        good;
    } frame_result_t;

    // shadow decoder state
    logic [COUNT_W-1:0] bytes_in_frame;
    logic [7:0]         frame_buf [STORE_LEN];
    chan_array_t        held_chans;
    logic               held_fs;
    frame_result_t      owed_frames [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%s mismatch: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // footer beat: unpack the channel bit string if the footer is good, else repeat held
    function automatic frame_result_t decode_footer(input logic [7:0] footer);
        logic [STORE_LEN*8-1:0] flat;
        frame_result_t          r;
        for (int k = 0; k < STORE_LEN; k++)
            flat[8*k +: 8] = frame_buf[k];
        if (footer == FTR_BYTE)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
                held_chans[i] = flat[CHAN_BASE + CHAN_W*i +: CHAN_W];
            held_fs = frame_buf[FAILSAFE_IDX][FAILSAFE_BIT];
        end
        r.chans    = held_chans;
        r.failsafe = held_fs;
        r.good     = (footer == FTR_BYTE);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_result_t want;
        chan_array_t   seen;
        if (!rst_n)
        begin
            bytes_in_frame = '0;
            held_chans     = '0;
            held_fs        = 1'b0;
            owed_frames.delete();
            mismatch_count = 0;
            frames_owed    = 0;
        end
        else
        begin
            // result beat against the oldest owed frame
            if (out_valid && !out_stall)
            begin
                if (owed_frames.size() == 0)
                    report_mismatch("unexpected result beat", 1, 0);
                else
                begin
                    want = owed_frames.pop_front();
                    seen = {chan_9, chan_8, chan_7, chan_6, chan_5,
                            chan_4, chan_3, chan_2, chan_1, chan_0};
                    for (int i = 0; i < NUM_CHANNELS; i++)
                        if (seen[i] !== want.chans[i])
                            report_mismatch($sformatf("chan_%0d", i),
                                            int'(seen[i]), int'(want.chans[i]));
                    if (failsafe_on !== want.failsafe)
                        report_mismatch("failsafe_on", int'(failsafe_on),
                                        int'(want.failsafe));
                    if (frame_good !== want.good)
                        report_mismatch("frame_good", int'(frame_good), int'(want.good));
                end
            end

            // byte beat: hunt for header, collect, close on footer
            if (in_valid && !in_stall)
            begin
                if (bytes_in_frame == FOOTER_POS)
                begin
                    owed_frames.push_back(decode_footer(rx_byte));
                    bytes_in_frame = '0;
                end
                else if (bytes_in_frame != 0 || rx_byte == HDR_BYTE)
                begin
                    frame_buf[bytes_in_frame] = rx_byte;
                    bytes_in_frame++;
                end
            end

            frames_owed = owed_frames.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sbusfd_pkg::*;

    localparam int BYTE_TARGET = 1650;

    typedef enum int {
        FILL_ONES,
        FILL_ZEROS,
        FILL_HDR_MIX,
        FILL_RANDOM
    } fill_kind_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [10:0] chan_0;
    logic [10:0] chan_1;
    logic [10:0] chan_2;
    logic [10:0] chan_3;
    logic [10:0] chan_4;
    logic [10:0] chan_5;
    logic [10:0] chan_6;
    logic [10:0] chan_7;
    logic [10:0] chan_8;
    logic [10:0] chan_9;
    logic        failsafe_on;
    logic        frame_good;
    int          mismatch_count;
    int          frames_owed;

    int bytes_sent;
    int quiet_frames;
    int quiet_results;

    sbus_frame_decoder_core u_top (.*);

    sbus_frame_checker u_checker (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // reset, once
    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // one byte beat with a random lead-in gap, none during quiet frames
    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = (quiet_frames > 0) ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte  <= value;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    // header, 23 body bytes, footer
    task automatic send_frame(input fill_kind_t fill, input logic [7:0] footer);
        logic [7:0] b;
        send_byte(HDR_BYTE);
        for (int k = 1; k < FRAME_LEN - 1; k++)
        begin
            case (fill)
                FILL_ONES:    b = 8'hFF;
                FILL_ZEROS:   b = 8'h00;
                FILL_HDR_MIX: b = $urandom_range(0, 1) ? HDR_BYTE : 8'($urandom);
                default:      b = 8'($urandom);
            endcase
            send_byte(b);
        end
        send_byte(footer);
    endtask

    // result side stall pattern
    initial
    begin : receiver
        int hold;
        out_stall     = 1'b0;
        quiet_results = 0;
        wait (rst_n);
        forever
        begin
            if (quiet_results > 0)
            begin
                hold = 0;
                quiet_results--;
            end
            else
            begin
                hold = $urandom_range(0, 13);
                if ($urandom_range(0, 7) == 0)
                    quiet_results = 10;
            end
            if (hold > 0)
            begin
                @(negedge clk) out_stall <= 1'b1;
                repeat (hold - 1) @(negedge clk);
            end
            @(negedge clk) out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid || out_stall);
        end
    end

    // byte stream
    initial
    begin : stimulus
        fill_kind_t  fill;
        logic [7:0]  footer;
        int          pick;
        int          len;
        logic [7:0]  junk;
        in_valid     = 1'b0;
        rx_byte      = 8'h00;
        bytes_sent   = 0;
        quiet_frames = 0;
        wait (rst_n);

        // noise while hunting, header inside a frame, bad footer before any good frame
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h0E);
        send_byte(HDR_BYTE);
        for (int k = 1; k < FRAME_LEN - 1; k++)
            send_byte((k == 5) ? HDR_BYTE : 8'hFF);
        send_byte(8'hFF);

        // hold off until the decoder has drained
        @(negedge clk) in_valid <= 1'b0;
        wait (frames_owed == 0);

        // mostly well-formed frames, some noise and broken frames
        while (bytes_sent < BYTE_TARGET)
        begin
            if (quiet_frames > 0)
                quiet_frames--;
            else if ($urandom_range(0, 5) == 0)
                quiet_frames = 3;

            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                // header plus a random run of bytes, short or overlong, realigns on whatever follows
                send_byte(HDR_BYTE);
                len = $urandom_range(1, 30);
                repeat (len) send_byte(8'($urandom));
            end
            else if (pick == 1)
            begin
                len = $urandom_range(1, 4);
                repeat (len)
                begin
                    do junk = 8'($urandom); while (junk == HDR_BYTE);
                    send_byte(junk);
                end
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       fill = FILL_ONES;
                    1:       fill = FILL_ZEROS;
                    2:       fill = FILL_HDR_MIX;
                    default: fill = FILL_RANDOM;
                endcase
                if ($urandom_range(0, 3) == 0)
                    footer = $urandom_range(0, 1) ? 8'hFF : 8'($urandom_range(1, 254));
                else
                    footer = FTR_BYTE;
                send_frame(fill, footer);
            end
        end

        @(negedge clk) in_valid <= 1'b0;
        wait (frames_owed == 0);
        repeat (30) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
